// ===== hdl/isodt_pkg.sv =====
// Shared types, codes and date tables for the dateTime-to-epoch parser.
`timescale 1ns / 1ps
package isodt_pkg;

  typedef enum logic [4:0] {
    PH_YEAR, PH_DASH1, PH_MON, PH_DASH2, PH_DAY, PH_T, PH_HOUR, PH_COL1,
    PH_MIN, PH_COL2, PH_SEC, PH_AFTSEC, PH_FRAC, PH_TZH, PH_TZCOL, PH_TZM,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CS_PARSE, CS_CONV0, CS_CONV1, CS_CONV2
  } ctrl_state_t;

  typedef struct packed {
    logic feed;      // take the character on the input ports
    logic step0;     // load first conversion stage
    logic step1;     // load second conversion stage
    logic load_out;  // load result register, clear parse state
  } dp_cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NEG    = 2'd3;

  localparam int EpochW = 39;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  // Day of a March-based year on which each month starts.
  function automatic logic [8:0] month_start(input logic [6:0] m);
    logic [8:0] r;
    case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      7'd2:                          r = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:       r = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8,
      7'd10, 7'd12:                  r = 5'd31;
      default:                       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/iso8601_datetime_to_epoch.sv =====
// Top level: dateTime text stream in, UTC epoch seconds and status out.
//
// Input channel: one ASCII character per item (in_char_code), with in_last
// marking the final character of a string. A character is taken at a clock
// edge where in_valid is high and in_stall is low.
// Result channel: one item per string, out_epoch_seconds (signed, zero on
// error) and out_status (ok, bad format, out of range, negative date).
// Throughput: one character per cycle while a string is being parsed.
// After the last character the block stalls its input while the
// date-to-seconds conversion runs through its three registered stages
// (century counts, day count, seconds multiply); the last stage loads the
// output register, and waits while that register holds a stalled item.
// The result register holds its item while out_stall is high; parsing of
// the next string proceeds meanwhile, and only the final load waits.
// Reset (rst_n low, synchronous) clears the parse state, the controller
// and out_valid; result payload registers are not reset.
`timescale 1ns / 1ps
module iso8601_datetime_to_epoch (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_char_code,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [isodt_pkg::EpochW-1:0]   out_epoch_seconds,
  output logic [1:0]                            out_status
);
  import isodt_pkg::*;

  dp_cmd_t cmd;

  isodt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  isodt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_char_code      (in_char_code),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status)
  );
endmodule

// ===== hdl/isodt_ctrl.sv =====
// Controller: parse / convert / result handoff sequencing.
`timescale 1ns / 1ps
module isodt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output isodt_pkg::dp_cmd_t cmd
);
  import isodt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_PARSE: if (in_valid && in_last) state_nxt = CS_CONV0;
      CS_CONV0: state_nxt = CS_CONV1;
      CS_CONV1: state_nxt = CS_CONV2;
      CS_CONV2: if (out_free) state_nxt = CS_PARSE;
      default:  state_nxt = CS_PARSE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      CS_PARSE: begin
        in_stall = 1'b0;
        cmd.feed = in_valid;
      end
      CS_CONV0: cmd.step0 = 1'b1;
      CS_CONV1: cmd.step1 = 1'b1;
      CS_CONV2: cmd.load_out = out_free;
      default:  cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== hdl/isodt_dp.sv =====
// Datapath: character parser registers, date conversion stages, result register.
`timescale 1ns / 1ps
module isodt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  isodt_pkg::dp_cmd_t               cmd,
  input  logic [7:0]                       in_char_code,
  output logic signed [isodt_pkg::EpochW-1:0] out_epoch_seconds,
  output logic [1:0]                       out_status
);
  import isodt_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  digit_r, digit_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  mon_r, mon_nxt, day_r, day_nxt, hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt, sec_r, sec_nxt, zh_r, zh_nxt, zm_r, zm_nxt;
  logic [1:0]  zsign_r, zsign_nxt, err_r, err_nxt;

  logic        is_dig;
  logic [3:0]  dig;
  logic [6:0]  cur2, new2;
  logic [13:0] new_year;
  logic [2:0]  digit_inc;

  assign is_dig    = (in_char_code >= 8'h30) && (in_char_code <= 8'h39);
  assign dig       = in_char_code[3:0];
  assign digit_inc = digit_r + 3'd1;
  assign new_year  = 14'(year_r * 14'd10 + 14'(dig));

  always_comb begin
    case (phase_r)
      PH_MON:  cur2 = mon_r;
      PH_DAY:  cur2 = day_r;
      PH_HOUR: cur2 = hour_r;
      PH_MIN:  cur2 = min_r;
      PH_SEC:  cur2 = sec_r;
      PH_TZH:  cur2 = zh_r;
      PH_TZM:  cur2 = zm_r;
      default: cur2 = 7'd0;
    endcase
  end
  assign new2 = 7'(cur2 * 7'd10 + 7'(dig));

  always_comb begin
    phase_nxt = phase_r;  digit_nxt = digit_r;  year_nxt = year_r;
    mon_nxt = mon_r;  day_nxt = day_r;  hour_nxt = hour_r;  min_nxt = min_r;
    sec_nxt = sec_r;  zh_nxt = zh_r;  zm_nxt = zm_r;
    zsign_nxt = zsign_r;  err_nxt = err_r;
    if (cmd.feed && err_r == ST_OK) begin
      case (phase_r)
        PH_YEAR: begin
          if (digit_r == 3'd0 && in_char_code == CH_MINUS) err_nxt = ST_NEG;
          else if (!is_dig) err_nxt = ST_FORMAT;
          else begin
            year_nxt = new_year;
            if (digit_inc >= 3'd4) begin
              digit_nxt = 3'd0;
              phase_nxt = PH_DASH1;
            end else digit_nxt = digit_inc;
          end
        end
        PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_TZH, PH_TZM: begin
          if (!is_dig) err_nxt = ST_FORMAT;
          else begin
            case (phase_r)
              PH_MON:  mon_nxt  = new2;
              PH_DAY:  day_nxt  = new2;
              PH_HOUR: hour_nxt = new2;
              PH_MIN:  min_nxt  = new2;
              PH_SEC:  sec_nxt  = new2;
              PH_TZH:  zh_nxt   = new2;
              default: zm_nxt   = new2;
            endcase
            if (digit_inc >= 3'd2) begin
              digit_nxt = 3'd0;
              case (phase_r)
                PH_MON:  phase_nxt = PH_DASH2;
                PH_DAY:  phase_nxt = PH_T;
                PH_HOUR: phase_nxt = PH_COL1;
                PH_MIN:  phase_nxt = PH_COL2;
                PH_SEC:  phase_nxt = PH_AFTSEC;
                PH_TZH:  phase_nxt = PH_TZCOL;
                default: phase_nxt = PH_DONE;
              endcase
            end else digit_nxt = digit_inc;
          end
        end
        PH_DASH1: if (in_char_code == CH_MINUS) phase_nxt = PH_MON;   else err_nxt = ST_FORMAT;
        PH_DASH2: if (in_char_code == CH_MINUS) phase_nxt = PH_DAY;   else err_nxt = ST_FORMAT;
        PH_T:     if (in_char_code == CH_T)     phase_nxt = PH_HOUR;  else err_nxt = ST_FORMAT;
        PH_COL1:  if (in_char_code == CH_COLON) phase_nxt = PH_MIN;   else err_nxt = ST_FORMAT;
        PH_COL2:  if (in_char_code == CH_COLON) phase_nxt = PH_SEC;   else err_nxt = ST_FORMAT;
        PH_TZCOL: if (in_char_code == CH_COLON) phase_nxt = PH_TZM;   else err_nxt = ST_FORMAT;
        PH_AFTSEC, PH_FRAC: begin
          if (phase_r == PH_AFTSEC && in_char_code == CH_DOT) begin
            digit_nxt = 3'd0;
            phase_nxt = PH_FRAC;
          end else if (phase_r == PH_FRAC && is_dig) begin
            digit_nxt = 3'd1;
          end else if (phase_r == PH_FRAC && digit_r == 3'd0) begin
            err_nxt = ST_FORMAT;
          end else if (in_char_code == CH_Z) begin
            phase_nxt = PH_DONE;
          end else if (in_char_code == CH_PLUS || in_char_code == CH_MINUS) begin
            zsign_nxt = (in_char_code == CH_PLUS) ? 2'd1 : 2'd2;
            digit_nxt = 3'd0;
            phase_nxt = PH_TZH;
          end else err_nxt = ST_FORMAT;
        end
        default: err_nxt = ST_FORMAT;  // text after a complete zone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      phase_r <= PH_YEAR;  digit_r <= '0;  year_r <= '0;  mon_r <= '0;
      day_r <= '0;  hour_r <= '0;  min_r <= '0;  sec_r <= '0;
      zh_r <= '0;  zm_r <= '0;  zsign_r <= '0;  err_r <= ST_OK;
    end else begin
      phase_r <= phase_nxt;  digit_r <= digit_nxt;  year_r <= year_nxt;
      mon_r <= mon_nxt;  day_r <= day_nxt;  hour_r <= hour_nxt;
      min_r <= min_nxt;  sec_r <= sec_nxt;  zh_r <= zh_nxt;  zm_r <= zm_nxt;
      zsign_r <= zsign_nxt;  err_r <= err_nxt;
    end
  end

  // Stage 0: leap year, shifted year and its century counts, partial sums.
  logic [7:0]  y_cent, yy_cent;
  logic [13:0] y_rem, yy;
  logic [11:0] yy_q;
  logic        leap;
  logic        leap_r, complete_r;
  logic [13:0] yy_r;
  logic [11:0] q_r;
  logic [7:0]  c_r;
  logic [9:0]  doy_r;
  logic [18:0] hms_r, off_r;

  assign y_cent  = 8'((23'(year_r[13:2]) * 23'd1311) >> 15);  // year / 100
  assign y_rem   = 14'(year_r - 14'(y_cent) * 14'd100);
  assign leap    = (year_r[1:0] == 2'd0) && (y_rem != 14'd0 || y_cent[1:0] == 2'd0);
  assign yy      = (mon_r <= 7'd2) ? 14'(year_r - 14'd1) : year_r;
  assign yy_q    = yy[13:2];
  assign yy_cent = 8'((23'(yy_q) * 23'd1311) >> 15);

  always_ff @(posedge clk) begin
    if (cmd.step0) begin
      leap_r     <= leap;
      yy_r       <= yy;
      q_r        <= yy_q;
      c_r        <= yy_cent;
      doy_r      <= 10'(10'(month_start(mon_r)) + 10'(day_r) - 10'd1);
      hms_r      <= 19'(19'(hour_r) * 19'd3600 + 19'(min_r) * 19'd60 + 19'(sec_r));
      off_r      <= 19'(19'(zh_r) * 19'd3600 + 19'(zm_r) * 19'd60);
      complete_r <= (phase_r == PH_AFTSEC) || (phase_r == PH_DONE) ||
                    (phase_r == PH_FRAC && digit_r != 3'd0);
    end
  end

  // Stage 1: day count and range checks.
  logic signed [23:0] days_r;
  logic               range_ok_r;
  logic               range_ok;

  assign range_ok = (year_r != 14'd0) && (mon_r >= 7'd1) && (mon_r <= 7'd12) &&
                    (day_r >= 7'd1) && (day_r <= 7'(month_len(mon_r, leap_r))) &&
                    (min_r <= 7'd59) && (sec_r <= 7'd59) && (hour_r <= 7'd24) &&
                    !(hour_r == 7'd24 && (min_r != 7'd0 || sec_r != 7'd0)) &&
                    (zh_r <= 7'd14) && (zm_r <= 7'd59) &&
                    !(zh_r == 7'd14 && zm_r != 7'd0);

  always_ff @(posedge clk) begin
    if (cmd.step1) begin
      days_r <= 24'(24'(yy_r) * 24'sd365 + 24'(q_r) - 24'(c_r) + 24'(c_r[7:2]) +
                    24'(doy_r) - 24'sd719468);
      range_ok_r <= range_ok;
    end
  end

  // Stage 2: seconds, zone offset, status into the result register.
  logic signed [EpochW-1:0] secs;
  logic [1:0]               status;

  always_comb begin
    secs = EpochW'(days_r) * EpochW'(86400) + EpochW'(hms_r);
    if (zsign_r == 2'd1)      secs = secs - EpochW'(off_r);
    else if (zsign_r == 2'd2) secs = secs + EpochW'(off_r);
    if (err_r != ST_OK)   status = err_r;
    else if (!complete_r) status = ST_FORMAT;
    else if (!range_ok_r) status = ST_RANGE;
    else                  status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= status;
      out_epoch_seconds <= (status == ST_OK) ? secs : '0;
    end
  end
endmodule

// ===== hdl/isodt_checker.sv =====
// Port-level checker for the dateTime parser, bound to the top level.
`timescale 1ns / 1ps
module isodt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [isodt_pkg::EpochW-1:0] out_epoch_seconds,
  input logic [1:0]                          out_status
);
  import isodt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_epoch_seconds) && $stable(out_status))
    else $error("result item changed while stalled");

  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not held off during conversion");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_epoch_seconds == '0)
    else $error("nonzero seconds on error status");
endmodule

bind iso8601_datetime_to_epoch isodt_checker u_isodt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last           (in_last),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_epoch_seconds (out_epoch_seconds),
  .out_status        (out_status)
);
